// ----- hdl/mist_pkg.sv -----
// Shared types and constants for the minimum-image support counter.
// No dependencies; imported by the lane, merge and top-level modules.
`default_nettype none
package mist_pkg;

	localparam int ID_W        = 12;
	localparam int CMD_W       = 2;
	localparam int PSIZE_W     = 4;
	localparam int SUP_W       = 13;
	localparam int FIELD_LANES = 8;
	localparam int ID_SPAN     = 1 << ID_W;
	localparam logic [SUP_W-1:0] SUP_MAX = '1;

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADDR,
		ST_READ,
		ST_WRITE,
		ST_MERGE
	} state_t;

	typedef struct packed {
		logic start;
		logic wipe;
		logic rd_en;
		logic wr_en;
		logic add;
		logic clr_en;
	} lane_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/minimum_image_support_counter.sv -----
// Minimum-image support counter: an add or remove beat goes through id reduction (when
// VERTEX_IDS is below 4096) and the read-modify-write of each lane's count RAM, then to
// the merge; clear or unused commands go straight to the merge. No new beat is taken until
// the merge has loaded the last one, waiting while an output is held. Reset, a clear
// command and a pattern_size write start a clearing pass over all lanes' RAMs; no input
// beat is taken meanwhile. Depends on mist_pkg, mist_lane, mist_merge and mist_ram.
`default_nettype none
module minimum_image_support_counter #(
	parameter int MAX_PATTERN = 8,
	parameter int VERTEX_IDS  = 4096,
	parameter int COUNT_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [mist_pkg::PSIZE_W-1:0]  cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [mist_pkg::CMD_W-1:0]    cmd,
	input  wire logic [mist_pkg::ID_W-1:0]     vertex_0,
	input  wire logic [mist_pkg::ID_W-1:0]     vertex_1,
	input  wire logic [mist_pkg::ID_W-1:0]     vertex_2,
	input  wire logic [mist_pkg::ID_W-1:0]     vertex_3,
	input  wire logic [mist_pkg::ID_W-1:0]     vertex_4,
	input  wire logic [mist_pkg::ID_W-1:0]     vertex_5,
	input  wire logic [mist_pkg::ID_W-1:0]     vertex_6,
	input  wire logic [mist_pkg::ID_W-1:0]     vertex_7,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [mist_pkg::SUP_W-1:0]    support_value,
	output logic                               underflow
);
	import mist_pkg::*;

	localparam int LANES    = (MAX_PATTERN < FIELD_LANES) ? MAX_PATTERN : FIELD_LANES;
	localparam int AW       = $clog2(VERTEX_IDS);
	localparam int DW       = $clog2(VERTEX_IDS + 1);
	localparam bit NEED_MOD = (VERTEX_IDS < ID_SPAN);
	localparam int ADDR_LAT = 3;
	localparam logic [AW-1:0] CLR_LAST = AW'(VERTEX_IDS - 1);

	state_t              state_q, state_nxt;
	logic [PSIZE_W-1:0]  psize_q;
	logic [ID_W-1:0]     vtx_q [FIELD_LANES];
	logic [ID_W-1:0]     vtx_in [FIELD_LANES];
	logic                add_q;
	logic                clear_pend_q;
	logic [AW-1:0]       clr_addr_q;
	logic [1:0]          wait_q;
	logic                in_fire, cfg_fire, slot_free, merge_load;
	lane_ctrl_t          ctrl;
	logic [LANES-1:0]    active;
	logic [LANES-1:0]    under;
	logic [DW-1:0]       distinct [LANES];

	assign vtx_in = '{vertex_0, vertex_1, vertex_2, vertex_3,
	                  vertex_4, vertex_5, vertex_6, vertex_7};

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign cfg_fire   = cfg_valid && cfg_ready;
	assign slot_free  = !out_valid || out_ready;
	assign merge_load = (state_q == ST_MERGE) && slot_free;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			active[i] = (PSIZE_W'(i) < psize_q);
		end
	end

	always_comb begin
		state_nxt   = state_q;
		ctrl.start  = in_fire;
		ctrl.wipe   = cfg_fire || (in_fire && cmd == CMD_CLEAR);
		ctrl.rd_en  = (state_q == ST_READ);
		ctrl.wr_en  = (state_q == ST_WRITE);
		ctrl.add    = add_q;
		ctrl.clr_en = (state_q == ST_CLEAR);
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == CLR_LAST) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_fire) begin
					if (cmd == CMD_ADD || cmd == CMD_REMOVE) begin
						state_nxt = NEED_MOD ? ST_ADDR : ST_READ;
					end else begin
						state_nxt = ST_MERGE;
					end
				end
			end
			ST_ADDR: begin
				if (wait_q == 2'(ADDR_LAT - 1)) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ:  state_nxt = ST_WRITE;
			ST_WRITE: state_nxt = ST_MERGE;
			ST_MERGE: begin
				if (slot_free) begin
					state_nxt = clear_pend_q ? ST_CLEAR : ST_IDLE;
				end
			end
			default:  state_nxt = ST_IDLE;
		endcase
		if (cfg_fire) begin
			state_nxt = ST_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			psize_q      <= '0;
			add_q        <= 1'b0;
			clear_pend_q <= 1'b0;
			clr_addr_q   <= '0;
			wait_q       <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_fire) begin
				psize_q <= cfg_data;
			end
			if (in_fire) begin
				add_q        <= (cmd == CMD_ADD);
				clear_pend_q <= (cmd == CMD_CLEAR);
			end
			if (state_q == ST_CLEAR && !cfg_fire) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end else begin
				clr_addr_q <= '0;
			end
			if (state_q == ST_ADDR) begin
				wait_q <= wait_q + 2'd1;
			end else begin
				wait_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			vtx_q <= vtx_in;
		end
	end

	generate
		for (genvar g = 0; g < LANES; g++) begin : gen_lane
			mist_lane #(
				.VERTEX_IDS(VERTEX_IDS),
				.COUNT_BITS(COUNT_BITS)
			) u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.id      (vtx_q[g]),
				.active  (active[g]),
				.ctrl    (ctrl),
				.clr_addr(clr_addr_q),
				.distinct(distinct[g]),
				.under   (under[g])
			);
		end
	endgenerate

	mist_merge #(
		.LANES(LANES),
		.DW   (DW)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (merge_load),
		.distinct     (distinct),
		.under        (under),
		.active       (active),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.support_value(support_value),
		.underflow    (underflow)
	);

endmodule
`default_nettype wire

// ----- hdl/mist_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module mist_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/mist_lane.sv -----
// One pattern-vertex lane: id reduction, occurrence-count table and distinct count.
// Depends on mist_pkg and mist_ram.
`default_nettype none
module mist_lane #(
	parameter int VERTEX_IDS = 4096,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [mist_pkg::ID_W-1:0]           id,
	input  wire logic                                active,
	input  wire mist_pkg::lane_ctrl_t                ctrl,
	input  wire logic [$clog2(VERTEX_IDS)-1:0]       clr_addr,
	output logic      [$clog2(VERTEX_IDS+1)-1:0]     distinct,
	output logic                                     under
);
	import mist_pkg::*;

	localparam int AW = $clog2(VERTEX_IDS);
	localparam int DW = $clog2(VERTEX_IDS + 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [AW-1:0]         addr;
	logic [COUNT_BITS-1:0] rd_data;
	logic [COUNT_BITS-1:0] cnt_nxt;
	logic                  cnt_we;
	logic                  hit_zero;
	logic [DW-1:0]         distinct_q;
	logic                  under_q;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;

	generate
		if (VERTEX_IDS < ID_SPAN) begin : gen_mod
			localparam int SH = 24;
			localparam logic [SH-1:0]   RECIP = SH'((64'd1 << SH) / VERTEX_IDS);
			localparam logic [ID_W-1:0] VMOD  = ID_W'(VERTEX_IDS);

			logic [ID_W-1:0]      id_s1, id_s2;
			logic [ID_W-1:0]      quo_s1;
			logic [ID_W-1:0]      prod_s2;
			logic [AW-1:0]        addr_s3;
			logic [ID_W+SH-1:0]   prod_a;
			logic [2*ID_W-1:0]    prod_b;
			logic [ID_W-1:0]      rem;

			always_comb begin
				prod_a = (ID_W+SH)'(id) * (ID_W+SH)'(RECIP);
				prod_b = (2*ID_W)'(quo_s1) * (2*ID_W)'(VMOD);
				rem    = id_s2 - prod_s2;
				if (rem >= VMOD) begin
					rem = rem - VMOD;
				end
			end

			always_ff @(posedge clk) begin
				id_s1   <= id;
				quo_s1  <= prod_a[ID_W+SH-1:SH];
				id_s2   <= id_s1;
				prod_s2 <= prod_b[ID_W-1:0];
				addr_s3 <= rem[AW-1:0];
			end

			assign addr = addr_s3;
		end else begin : gen_direct
			assign addr = AW'(id);
		end
	endgenerate

	always_comb begin
		hit_zero = (rd_data == '0);
		cnt_nxt  = rd_data;
		cnt_we   = 1'b0;
		if (ctrl.wr_en && active) begin
			if (ctrl.add) begin
				cnt_we = 1'b1;
				if (rd_data != CNT_MAX) begin
					cnt_nxt = rd_data + COUNT_BITS'(1);
				end
			end else if (!hit_zero) begin
				cnt_we  = 1'b1;
				cnt_nxt = rd_data - COUNT_BITS'(1);
			end
		end
		ram_we    = ctrl.clr_en || cnt_we;
		ram_waddr = ctrl.clr_en ? clr_addr : addr;
		ram_wdata = ctrl.clr_en ? '0 : cnt_nxt;
	end

	mist_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(VERTEX_IDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ctrl.rd_en),
		.raddr(addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distinct_q <= '0;
			under_q    <= 1'b0;
		end else begin
			if (ctrl.start) begin
				under_q <= 1'b0;
			end else if (ctrl.wr_en && active && !ctrl.add && hit_zero) begin
				under_q <= 1'b1;
			end
			if (ctrl.wipe) begin
				distinct_q <= '0;
			end else if (ctrl.wr_en && active) begin
				if (ctrl.add && hit_zero) begin
					distinct_q <= distinct_q + DW'(1);
				end else if (!ctrl.add && rd_data == COUNT_BITS'(1)) begin
					distinct_q <= distinct_q - DW'(1);
				end
			end
		end
	end

	assign distinct = distinct_q;
	assign under    = under_q;

endmodule
`default_nettype wire

// ----- hdl/mist_merge.sv -----
// Merging stage: minimum distinct count over active lanes, underflow OR, output register.
// Depends on mist_pkg.
`default_nettype none
module mist_merge #(
	parameter int LANES = 8,
	parameter int DW    = 13
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire logic [DW-1:0]               distinct [LANES],
	input  wire logic [LANES-1:0]            under,
	input  wire logic [LANES-1:0]            active,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output logic      [mist_pkg::SUP_W-1:0]  support_value,
	output logic                             underflow
);
	import mist_pkg::*;

	localparam int CW = (DW > SUP_W) ? DW : SUP_W;

	logic [DW-1:0]    best;
	logic [CW-1:0]    best_x;
	logic             any_act;
	logic [SUP_W-1:0] sup_nxt;
	logic             out_valid_q;
	logic [SUP_W-1:0] support_q;
	logic             under_q;

	always_comb begin
		best    = '1;
		any_act = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			if (active[i] && distinct[i] < best) begin
				best = distinct[i];
			end
			any_act = any_act | active[i];
		end
		best_x = CW'(best);
		if (!any_act) begin
			sup_nxt = '0;
		end else if (best_x > CW'(SUP_MAX)) begin
			sup_nxt = SUP_MAX;
		end else begin
			sup_nxt = best_x[SUP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			support_q <= sup_nxt;
			under_q   <= |(under & active);
		end
	end

	assign out_valid     = out_valid_q;
	assign support_value = support_q;
	assign underflow     = under_q;

endmodule
`default_nettype wire

// ----- tb/sv/tb_minimum_image_support_counter.sv -----
// Self-checking bench for minimum_image_support_counter: directed rows, then random embeddings
// under several idle/stall mixes, every result beat checked against typed or modelled support.
// Depends on mist_pkg and the counter RTL.
`timescale 1ns / 1ps
module tb_minimum_image_support_counter;
	import mist_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int LANES        = 8;
	localparam int ID_COUNT     = 4096;
	localparam logic [15:0] COUNT_SAT = 16'hFFFF;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_BEATS  = 450;

	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic [LANES-1:0][ID_W-1:0] ids;
	} beat_t;

	typedef struct packed {
		logic [SUP_W-1:0] sup;
		logic uf;
	} support_beat_t;

	typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [PSIZE_W-1:0] size;
		beat_t beat;
		logic typed_chk;
		support_beat_t typed;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [PSIZE_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] beat_cmd = CMD_ADD;
	logic [LANES-1:0][ID_W-1:0] lane_ids = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [SUP_W-1:0] support_value;
	logic underflow;

	logic [15:0] occ_count [LANES][ID_COUNT];
	int unsigned distinct_ids [LANES];
	int unsigned lanes_on = 0;
	support_beat_t pending_support[$];
	logic [LANES-1:0][ID_W-1:0] live_embeds[$];

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_ticket = 0;
	int hold_served = 0;
	int hold_left = 0;
	int mismatches = 0;
	int results_seen = 0;
	int cycle_count = 0;

	minimum_image_support_counter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(beat_cmd),
		.vertex_0(lane_ids[0]),
		.vertex_1(lane_ids[1]),
		.vertex_2(lane_ids[2]),
		.vertex_3(lane_ids[3]),
		.vertex_4(lane_ids[4]),
		.vertex_5(lane_ids[5]),
		.vertex_6(lane_ids[6]),
		.vertex_7(lane_ids[7]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.support_value(support_value),
		.underflow(underflow)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic void wipe_counts();
		foreach (occ_count[l, i]) occ_count[l][i] = '0;
		foreach (distinct_ids[l]) distinct_ids[l] = 0;
	endfunction

	function automatic support_beat_t apply_embedding(input beat_t b);
		support_beat_t r;
		int unsigned best;
		logic [ID_W-1:0] id;
		r.uf = 1'b0;
		if (b.op == CMD_CLEAR) begin
			wipe_counts();
		end else if (b.op == CMD_ADD || b.op == CMD_REMOVE) begin
			for (int l = 0; l < lanes_on; l++) begin
				id = b.ids[l];
				if (b.op == CMD_ADD) begin
					if (occ_count[l][id] == 0) distinct_ids[l]++;
					if (occ_count[l][id] != COUNT_SAT) occ_count[l][id]++;
				end else if (occ_count[l][id] == 0) begin
					r.uf = 1'b1;
				end else begin
					occ_count[l][id]--;
					if (occ_count[l][id] == 0) distinct_ids[l]--;
				end
			end
		end
		best = 0;
		for (int l = 0; l < lanes_on; l++)
			if (l == 0 || distinct_ids[l] < best) best = distinct_ids[l];
		r.sup = (best > SUP_MAX) ? SUP_MAX : best[SUP_W-1:0];
		return r;
	endfunction

	function automatic logic [ID_W-1:0] near_id();
		if ($urandom_range(1) == 1) return ID_W'($urandom_range(5));
		return ID_W'(ID_COUNT - 1 - $urandom_range(5));
	endfunction

	function automatic beat_t draw_beat();
		beat_t b;
		int unsigned r;
		int unsigned k;
		r = $urandom_range(99);
		for (int l = 0; l < LANES; l++) b.ids[l] = near_id();
		if (r < 1) begin
			b.op = CMD_CLEAR;
			live_embeds.delete();
		end else if (r < 4) begin
			b.op = CMD_UNUSED;
		end else if (r < 56) begin
			b.op = CMD_ADD;
			if ($urandom_range(9) < 3) b.ids = {$urandom, $urandom, $urandom};
			if (live_embeds.size() < 64) live_embeds = {live_embeds, b.ids};
		end else begin
			b.op = CMD_REMOVE;
			if (live_embeds.size() != 0 && $urandom_range(3) != 0) begin
				k = $urandom_range(live_embeds.size() - 1);
				b.ids = live_embeds[k];
				live_embeds.delete(k);
			end
		end
		return b;
	endfunction

	function automatic stim_row_t cfg_row(input logic [PSIZE_W-1:0] v);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.size = v;
		return r;
	endfunction

	function automatic stim_row_t beat_row(input logic [CMD_W-1:0] op,
			input logic [LANES-1:0][ID_W-1:0] ids, input logic chk,
			input int sup, input logic uf);
		stim_row_t r;
		r = '0;
		r.kind = ROW_BEAT;
		r.beat.op = op;
		r.beat.ids = ids;
		r.typed_chk = chk;
		r.typed.sup = SUP_W'(sup);
		r.typed.uf = uf;
		return r;
	endfunction

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_support.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_pattern_size(input logic [PSIZE_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		lanes_on = (v > LANES) ? LANES : v;
		wipe_counts();
		live_embeds.delete();
	endtask

	task automatic offer_beat(input beat_t b, input logic typed_chk, input support_beat_t typed);
		support_beat_t model_out;
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		model_out = apply_embedding(b);
		pending_support = {pending_support, (typed_chk ? typed : model_out)};
		in_valid <= 1'b1;
		beat_cmd <= b.op;
		lane_ids <= b.ids;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	always @(posedge clk) begin : rx_side
		support_beat_t want;
		if (out_valid && out_ready) begin
			results_seen++;
			if (pending_support.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d unexpected: support %0d underflow %0b",
						results_seen, support_value, underflow);
			end else begin
				want = pending_support.pop_front();
				if (support_value !== want.sup || underflow !== want.uf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: support exp %0d got %0d, underflow exp %0b got %0b",
							results_seen, want.sup, support_value, want.uf, underflow);
				end
			end
		end
		if (hold_served != hold_ticket) begin
			hold_served = hold_ticket;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin : stimulus
		stim_row_t directed[$];
		int gap_mix [4];
		int stall_mix [4];
		logic [PSIZE_W-1:0] size_mix [4];

		wipe_counts();
		directed = {directed, cfg_row(4'd8)};
		directed = {directed, beat_row(CMD_ADD, '0, 1'b1, 1, 1'b0)};
		directed = {directed, beat_row(CMD_ADD, {LANES{12'hFFF}}, 1'b1, 2, 1'b0)};
		directed = {directed, beat_row(CMD_ADD, '0, 1'b1, 2, 1'b0)};
		directed = {directed, beat_row(CMD_REMOVE, {LANES{12'hFFF}}, 1'b1, 1, 1'b0)};
		directed = {directed, beat_row(CMD_REMOVE, {LANES{12'hFFF}}, 1'b1, 1, 1'b1)};
		directed = {directed, beat_row(CMD_UNUSED, {LANES{12'hFFF}}, 1'b1, 1, 1'b0)};
		directed = {directed, beat_row(CMD_CLEAR, {LANES{12'h5A5}}, 1'b1, 0, 1'b0)};
		directed = {directed, beat_row(CMD_REMOVE, '0, 1'b1, 0, 1'b1)};
		directed = {directed, beat_row(CMD_ADD, {LANES{12'hAAA}}, 1'b1, 1, 1'b0)};
		directed = {directed, beat_row(CMD_ADD, {LANES{12'h555}}, 1'b1, 2, 1'b0)};
		directed = {directed, beat_row(CMD_ADD, {12'd7, 12'd6, 12'd5, 12'd4, 12'd3, 12'd2,
			12'd1, 12'd0}, 1'b0, 0, 1'b0)};
		directed = {directed, beat_row(CMD_REMOVE, {12'h001, {7{12'hAAA}}}, 1'b0, 0, 1'b0)};
		directed = {directed, cfg_row(4'd0)};
		directed = {directed, beat_row(CMD_ADD, {LANES{12'hFFF}}, 1'b1, 0, 1'b0)};
		directed = {directed, beat_row(CMD_REMOVE, {LANES{12'h123}}, 1'b1, 0, 1'b0)};
		directed = {directed, cfg_row(4'd15)};
		directed = {directed, beat_row(CMD_ADD, '0, 1'b1, 1, 1'b0)};
		directed = {directed, beat_row(CMD_ADD, {12'd0, {7{12'd1}}}, 1'b1, 1, 1'b0)};
		directed = {directed, beat_row(CMD_REMOVE, '0, 1'b0, 0, 1'b0)};
		directed = {directed, cfg_row(4'd1)};
		directed = {directed, beat_row(CMD_ADD, {{7{12'hFFF}}, 12'd7}, 1'b1, 1, 1'b0)};
		directed = {directed, beat_row(CMD_ADD, {{7{12'h800}}, 12'd8}, 1'b1, 2, 1'b0)};
		directed = {directed, beat_row(CMD_REMOVE, {{7{12'h3C3}}, 12'd7}, 1'b1, 1, 1'b0)};
		directed = {directed, beat_row(CMD_REMOVE, {LANES{12'hFFF}}, 1'b1, 1, 1'b1)};

		gap_mix   = '{0, 56, 0, 29};
		stall_mix = '{0, 0, 56, 29};
		size_mix  = '{4'd8, 4'd2, 4'd15, PSIZE_W'($urandom_range(1, 7))};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG)
				write_pattern_size(directed[i].size);
			else
				offer_beat(directed[i].beat, directed[i].typed_chk, directed[i].typed);
		end

		for (int p = 0; p < 4; p++) begin
			write_pattern_size(size_mix[p]);
			send_gap_pct = gap_mix[p];
			recv_stall_pct = stall_mix[p];
			if (p == 0) hold_ticket++;
			repeat (PHASE_BEATS) offer_beat(draw_beat(), 1'b0, '0);
		end

		settle();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
